// File: src/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 byte stream hasher: round
// constants, initial hash, sequencer states and the core control bundle.
// -----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ROUNDS   = 64;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned HASH_WORDS = 8;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WORD_W-1:0] IV_TABLE [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_FOLD  = 5'b01000,
		S_OUT   = 5'b10000
	} seq_state_t;

	typedef struct packed {
		logic              shift_en;   // push a packed message word
		logic [WORD_W-1:0] shift_word;
		logic              start;      // load working vars from chain hash
		logic              step;       // run one round
		logic [5:0]        rnd;        // round index for the constant
		logic              fold;       // add working vars into chain hash
		logic              reinit;     // reload initial hash
	} core_ctrl_t;

endpackage
`default_nettype wire

// File: src/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: packs bytes into 512-bit blocks, pads on the
// closing item and returns the digest as eight 32-bit words.
// -----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  msg     | msg_valid, msg_stall | message_byte, byte_present, end_of_message
//  dig     | dig_valid, dig_stall | digest_word, word_index, digest_done
//
// A byte item is taken when msg_valid is high and msg_stall low. Each 64th
// byte starts a compression (load, 64 rounds on the shared round unit,
// fold), during which no new bytes are taken. A closing item feeds the pad
// bytes one per cycle (up to 64 per block, 72 in all when the length field
// spills into a second block), runs one or two compressions and then
// offers eight digest words, one per cycle when dig_stall stays low.
// msg_stall is high whenever the sequencer is not idle. Reset loads the
// initial hash and clears the byte count; no clearing pass is needed.
// -----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         msg_valid,
	output logic        msg_stall,
	input  wire  [7:0]  message_byte,
	input  wire         byte_present,
	input  wire         end_of_message,
	output logic        dig_valid,
	input  wire         dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_done
);
	import sha_pkg::*;

	seq_state_t  state_q;
	logic [5:0]  pos_q;       // byte position inside the current block
	logic [60:0] total_q;     // message bytes so far
	logic [63:0] len_q;       // bit length, shifted out a byte at a time
	logic [23:0] acc_q;       // earlier bytes of the word being packed
	logic [5:0]  rnd_q;
	logic        pad_q;       // message is closing
	logic        pad_first_q; // next pad byte is the 0x80 marker
	logic        len_ok_q;    // length field fits in the current block
	logic        final_q;     // running compression is the last one
	logic [2:0]  out_cnt_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_done_q;

	logic        msg_acc;
	logic        pack_en;
	logic [7:0]  pack_byte;
	logic        len_ok_eff;
	logic        use_len;
	logic        block_full;
	logic        out_load;
	logic [60:0] total_inc;
	logic [31:0] chain_word;
	core_ctrl_t  ctrl;

	assign msg_stall = (state_q != S_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;
	assign total_inc = total_q + 61'(byte_present);

	// pick the byte to pack: message byte when idle; in padding the marker first, then zeros, then the length field
	always_comb begin
		len_ok_eff = pad_first_q ? (pos_q < 6'd56) : len_ok_q;
		use_len    = !pad_first_q && len_ok_q && (pos_q[5:3] == 3'b111);
		unique case (state_q)
			S_IDLE: begin
				pack_en   = msg_acc && byte_present;
				pack_byte = message_byte;
			end
			S_PAD: begin
				pack_en   = 1'b1;
				pack_byte = pad_first_q ? PAD_BYTE : (use_len ? len_q[63:56] : 8'h00);
			end
			default: begin
				pack_en   = 1'b0;
				pack_byte = message_byte;
			end
		endcase
		block_full = pack_en && (pos_q == 6'd63);
		out_load   = (state_q == S_OUT) && (!out_valid_q || !dig_stall);
	end

	always_comb begin
		ctrl.shift_en   = pack_en && (pos_q[1:0] == 2'b11);
		ctrl.shift_word = {acc_q, pack_byte};
		ctrl.start      = block_full;
		ctrl.step       = (state_q == S_ROUND);
		ctrl.rnd        = rnd_q;
		ctrl.fold       = (state_q == S_FOLD);
		ctrl.reinit     = out_load && (out_cnt_q == 3'd7);
	end

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_idx  (out_cnt_q),
		.rd_word (chain_word)
	);

	// byte packer: hold up to three bytes until the word is complete
	always_ff @(posedge clk) begin
		if (pack_en) begin
			acc_q <= {acc_q[15:0], pack_byte};
		end
	end

	always_ff @(posedge clk) begin
		if (msg_acc && end_of_message) begin
			len_q <= {total_inc, 3'b000};
		end else if (state_q == S_PAD && use_len) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= chain_word;
			out_idx_q  <= out_cnt_q;
			out_done_q <= (out_cnt_q == 3'd7);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			total_q     <= '0;
			rnd_q       <= '0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
			out_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pack_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						total_q     <= end_of_message ? '0 : total_inc;
						pad_q       <= end_of_message;
						pad_first_q <= end_of_message;
						final_q     <= 1'b0;
						rnd_q       <= '0;
						if (block_full) begin
							state_q <= S_ROUND;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					len_ok_q    <= len_ok_eff;
					if (pos_q == 6'd63) begin
						// block done: the next one always has room for the length
						final_q  <= len_ok_eff;
						len_ok_q <= 1'b1;
						rnd_q    <= '0;
						state_q  <= S_ROUND;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (final_q) begin
						out_cnt_q <= '0;
						state_q   <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_cnt_q <= out_cnt_q + 3'd1;
						if (out_cnt_q == 3'd7) begin
							pad_q   <= 1'b0;
							final_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign dig_valid   = out_valid_q;
	assign digest_word = out_word_q;
	assign word_index  = out_idx_q;
	assign digest_done = out_done_q;

endmodule
`default_nettype wire

// File: src/sha_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sha_core
// One SHA-256 round per cycle while step is set, over a 16-word schedule
// window, with the working variables and the chaining hash.
// -----------------------------------------------------------------------------
module sha_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  sha_pkg::core_ctrl_t      ctrl,
	input  wire  [2:0]               rd_idx,
	output logic [sha_pkg::WORD_W-1:0] rd_word
);
	import sha_pkg::*;

	logic [WORD_W-1:0] w_q     [BLK_WORDS];
	logic [WORD_W-1:0] v_q     [HASH_WORDS];
	logic [WORD_W-1:0] chain_q [HASH_WORDS];

	logic [WORD_W-1:0] w_new;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] x1;
	logic [WORD_W-1:0] x14;
	logic [WORD_W-1:0] va;
	logic [WORD_W-1:0] ve;

	// schedule word and round terms t1, t2 from the small and big sigma functions
	always_comb begin
		x1  = w_q[1];
		x14 = w_q[14];
		va  = v_q[0];
		ve  = v_q[4];
		w_new = w_q[0] + w_q[9]
			+ ({x1[6:0], x1[31:7]} ^ {x1[17:0], x1[31:18]} ^ {3'b000, x1[31:3]})
			+ ({x14[16:0], x14[31:17]} ^ {x14[18:0], x14[31:19]}
				^ {10'd0, x14[31:10]});
		t1 = v_q[7]
			+ ({ve[5:0], ve[31:6]} ^ {ve[10:0], ve[31:11]} ^ {ve[24:0], ve[31:25]})
			+ ((ve & v_q[5]) ^ (~ve & v_q[6]))
			+ K_TABLE[ctrl.rnd] + w_q[0];
		t2 = ({va[1:0], va[31:2]} ^ {va[12:0], va[31:13]} ^ {va[21:0], va[31:22]})
			+ ((va & v_q[1]) ^ (va & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// schedule window: shift toward w_q[0]
	always_ff @(posedge clk) begin
		if (ctrl.shift_en || ctrl.step) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLK_WORDS-1] <= ctrl.shift_en ? ctrl.shift_word : w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (ctrl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= IV_TABLE[i];
			end
		end else if (ctrl.reinit) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= IV_TABLE[i];
			end
		end else if (ctrl.fold) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	assign rd_word = chain_q[rd_idx];

endmodule
`default_nettype wire
